### rtl/core/msb_pkg.sv
// ---------------------------------------------------------------------------
// msb_pkg
// Shared sizes, codes and request types for the shared-buffer stack block.
// ---------------------------------------------------------------------------
package msb_pkg;

  localparam int ENTRIES = 16;
  localparam int STACKS  = 4;

  // entry index, and pointer that can also hold null (the value ENTRIES)
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W   = $clog2(ENTRIES + 1);
  localparam int HEAD_AW = (STACKS > 1) ? $clog2(STACKS) : 1;

  localparam int OP_W    = 2;
  localparam int SID_W   = 2;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;

  localparam logic [PTR_W-1:0] PTR_NIL = PTR_W'(ENTRIES);

  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // request to the entry store (data + link memories)
  typedef struct packed {
    logic                     link_rd_en;
    logic                     data_rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic                     link_wr_en;
    logic                     data_wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [PTR_W-1:0]         link_wr_data;
    logic signed [DATA_W-1:0] data_wr_data;
  } entry_req_t;

  // request to the stack-head store
  typedef struct packed {
    logic               rd_en;
    logic [HEAD_AW-1:0] rd_addr;
    logic               wr_en;
    logic [HEAD_AW-1:0] wr_addr;
    logic [PTR_W-1:0]   wr_data;
  } head_req_t;

  function automatic logic is_entry(input logic [PTR_W-1:0] p);
    return p < PTR_NIL;
  endfunction

endpackage

### rtl/core/multi_stack_shared_buffer.sv
// ---------------------------------------------------------------------------
// multi_stack_shared_buffer
// Several stacks sharing one entry store, chained by links, with a free list.
// ---------------------------------------------------------------------------
// Sequence: push, no-op and refused transactions give their result from
//   S_HEAD, successful pop and peek from S_LINK (head read, then a
//   read of the top entry's link or data from the entry store).
// Flow: a new transaction is accepted only in S_IDLE, not while the last
//   one is in flight; busy is high while one is in flight.
// Reset: synchronous, active low; all stacks empty, free list 0..ENTRIES-1.
//   No clearing pass: ready the cycle after reset. Receiver cannot stall.
// ---------------------------------------------------------------------------
module multi_stack_shared_buffer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [msb_pkg::OP_W-1:0]          in_op,
  input  logic [msb_pkg::SID_W-1:0]         in_stack_id,
  input  logic signed [msb_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  output logic [msb_pkg::STAT_W-1:0]        out_status,
  output logic signed [msb_pkg::DATA_W-1:0] out_top_value,
  output logic                              out_store_full,
  output logic                              out_stack_empty
);
  import msb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,  // waiting for a transaction
    S_HEAD,  // stack head (and free-head link) read data is back
    S_LINK   // top entry's link (pop) or data (peek) is back
  } state_t;

  state_t                   state_r;
  logic [OP_W-1:0]          op_r;
  logic [SID_W-1:0]         sid_r;
  logic signed [DATA_W-1:0] val_r;
  logic                     vs_r;        // stack id names a real stack
  logic [PTR_W-1:0]         free_head_r, free_head_nxt;
  logic [PTR_W-1:0]         top_r;       // top entry of the addressed stack

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DATA_W-1:0] out_top_value_r;
  logic                     out_store_full_r;
  logic                     out_stack_empty_r;

  entry_req_t               ereq;
  head_req_t                hreq;
  logic [PTR_W-1:0]         link_rd;
  logic signed [DATA_W-1:0] data_rd;
  logic [PTR_W-1:0]         head_rd;
  logic                     accept;
  logic                     in_vs;

  assign accept = start && (state_r == S_IDLE);
  assign in_vs  = int'(in_stack_id) < STACKS;
  assign busy   = (state_r != S_IDLE);

  msb_entry_store u_entry (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (ereq),
    .link_rd_data (link_rd),
    .data_rd_data (data_rd)
  );

  msb_head_store u_head (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (head_rd)
  );

  // memory requests: reads issued at acceptance and in S_HEAD, writes land
  // on the closing edge of the transaction, so the next one sees them
  always_comb begin
    ereq              = '0;
    hreq              = '0;
    free_head_nxt     = free_head_r;
    ereq.data_wr_data = val_r;
    case (state_r)
      S_IDLE: begin
        hreq.rd_en   = accept && in_vs;
        hreq.rd_addr = HEAD_AW'(in_stack_id);
        // prefetch the link of the free head, needed by a push
        ereq.link_rd_en = accept && is_entry(free_head_r);
        ereq.rd_addr    = IDX_W'(free_head_r);
      end
      S_HEAD: begin
        if (op_r == OP_PUSH) begin
          if (vs_r && is_entry(free_head_r)) begin
            ereq.link_wr_en   = 1'b1;
            ereq.data_wr_en   = 1'b1;
            ereq.wr_addr      = IDX_W'(free_head_r);
            ereq.link_wr_data = head_rd;
            hreq.wr_en        = 1'b1;
            hreq.wr_addr      = HEAD_AW'(sid_r);
            hreq.wr_data      = free_head_r;
            free_head_nxt     = link_rd;
          end
        end else if (vs_r && is_entry(head_rd)) begin
          ereq.rd_addr    = IDX_W'(head_rd);
          ereq.link_rd_en = (op_r == OP_POP);
          ereq.data_rd_en = (op_r == OP_PEEK);
        end
      end
      S_LINK: begin
        if (op_r == OP_POP) begin
          // unlink top, return it to the free list head
          hreq.wr_en        = 1'b1;
          hreq.wr_addr      = HEAD_AW'(sid_r);
          hreq.wr_data      = link_rd;
          ereq.link_wr_en   = 1'b1;
          ereq.wr_addr      = IDX_W'(top_r);
          ereq.link_wr_data = free_head_r;
          free_head_nxt     = top_r;
        end
      end
      default: begin
        ereq = '0;
      end
    endcase
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            sid_r   <= in_stack_id;
            val_r   <= in_value;
            vs_r    <= in_vs;
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          top_r             <= head_rd;
          out_top_value_r   <= '0;
          out_status_r      <= ST_DONE;
          out_store_full_r  <= !is_entry(free_head_r);
          out_stack_empty_r <= !vs_r || !is_entry(head_rd);
          out_valid_r       <= 1'b1;
          state_r           <= S_IDLE;
          case (op_r)
            OP_PUSH: begin
              if (!vs_r) begin
                out_status_r <= ST_EMPTY;
              end else if (!is_entry(free_head_r)) begin
                out_status_r <= ST_FULL;
              end else begin
                out_store_full_r  <= !is_entry(link_rd);
                out_stack_empty_r <= 1'b0;
              end
            end
            OP_POP, OP_PEEK: begin
              if (!vs_r || !is_entry(head_rd)) begin
                out_status_r <= ST_EMPTY;
              end else begin
                out_valid_r <= 1'b0;
                state_r     <= S_LINK;
              end
            end
            default: begin
              // no-op code: report current state only
              out_status_r <= ST_DONE;
            end
          endcase
        end
        S_LINK: begin
          out_valid_r       <= 1'b1;
          out_status_r      <= ST_DONE;
          state_r           <= S_IDLE;
          if (op_r == OP_POP) begin
            out_top_value_r   <= '0;
            out_store_full_r  <= 1'b0;
            out_stack_empty_r <= !is_entry(link_rd);
          end else begin
            out_top_value_r   <= data_rd;
            out_store_full_r  <= !is_entry(free_head_r);
            out_stack_empty_r <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_top_value   = out_top_value_r;
  assign out_store_full  = out_store_full_r;
  assign out_stack_empty = out_stack_empty_r;

endmodule

### rtl/core/msb_entry_store.sv
// ---------------------------------------------------------------------------
// msb_entry_store
// Entry data and link memories, registered read.
// ---------------------------------------------------------------------------
module msb_entry_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  msb_pkg::entry_req_t              req,
  output logic [msb_pkg::PTR_W-1:0]        link_rd_data,
  output logic signed [msb_pkg::DATA_W-1:0] data_rd_data
);
  import msb_pkg::*;

  logic signed [DATA_W-1:0] data_mem [ENTRIES];
  logic [PTR_W-1:0]         link_mem [ENTRIES];

  logic [PTR_W-1:0]         link_q;
  logic signed [DATA_W-1:0] data_q;
  logic [PTR_W-1:0]         rd_ptr_r;
  logic                     virgin_r;
  // entries at or above the fill mark were never linked: they still
  // point to the next index (last one to null)
  logic [PTR_W-1:0]         fill_r;
  logic [PTR_W-1:0]         fill_nxt;

  always_ff @(posedge clk) begin
    if (req.link_wr_en) begin
      link_mem[req.wr_addr] <= req.link_wr_data;
    end
    if (req.data_wr_en) begin
      data_mem[req.wr_addr] <= req.data_wr_data;
    end
    if (req.link_rd_en) begin
      link_q   <= link_mem[req.rd_addr];
      rd_ptr_r <= PTR_W'(req.rd_addr);
      virgin_r <= PTR_W'(req.rd_addr) >= fill_r;
    end
    if (req.data_rd_en) begin
      data_q <= data_mem[req.rd_addr];
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (req.link_wr_en && (PTR_W'(req.wr_addr) == fill_r)) begin
      fill_nxt = fill_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign link_rd_data = virgin_r ? (rd_ptr_r + PTR_W'(1)) : link_q;
  assign data_rd_data = data_q;

endmodule

### rtl/core/msb_head_store.sv
// ---------------------------------------------------------------------------
// msb_head_store
// Per-stack top pointers, registered read, valid bits for reset.
// ---------------------------------------------------------------------------
module msb_head_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  msb_pkg::head_req_t        req,
  output logic [msb_pkg::PTR_W-1:0] rd_data
);
  import msb_pkg::*;

  logic [PTR_W-1:0]  head_mem [STACKS];
  logic [STACKS-1:0] vld_r;
  logic [PTR_W-1:0]  head_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      head_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      head_q <= head_mem[req.rd_addr];
      vld_q  <= vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  // an unwritten stack reads as empty
  assign rd_data = vld_q ? head_q : PTR_NIL;

endmodule

### rtl/core/msb_checker.sv
// ---------------------------------------------------------------------------
// msb_checker
// Port-level checks on the shared-buffer stack block, bound to the top.
// ---------------------------------------------------------------------------
module msb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [msb_pkg::STAT_W-1:0]        out_status,
  input logic signed [msb_pkg::DATA_W-1:0] out_top_value,
  input logic                              out_store_full
);
  import msb_pkg::*;

  // each transaction passes S_IDLE and S_HEAD, so results never abut
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on consecutive cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transaction");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_FULL ||
                   out_status == ST_EMPTY))
    else $error("illegal status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> (out_top_value == '0))
    else $error("refused transaction returned a value");

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_store_full)
    else $error("full refusal without store_full");

endmodule

bind multi_stack_shared_buffer msb_checker u_msb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_top_value  (out_top_value),
  .out_store_full (out_store_full)
);
